### hw/rtl/fof_pkg.sv
// Package for the formant grain synthesizer.
// Holds the controller state type, command and status structs, and fixed constants.
// No dependencies.
package fof_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FIN
  } fof_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic issue;
    logic load_out;
  } fof_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic pipe_busy;
    logic out_free;
  } fof_status_t;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_FORMANT_INC = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RISE_INC    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FALL_INC    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PERIODS     = 2'd3;

  localparam logic [23:0] RST_FORMANT_INC = 24'd228262;
  localparam logic [22:0] RST_RISE_INC    = 23'd262366;
  localparam logic [22:0] RST_FALL_INC    = 23'd9370;
  localparam logic [31:0] RST_PERIODS     = 32'd72980890;

  localparam logic [23:0] ENV_ONE  = 24'd4194304;
  localparam logic [24:0] ONE_Q24  = 25'd16777216;
  localparam int          SUM_MAX  = 2097151;
  localparam int          SUM_MIN  = -2097152;

endpackage

### hw/rtl/fof_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module fof_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/fof_ctrl.sv
// Sequencer for one audio sample: accept, walk the ring, drain, hand off the result.
// Depends on fof_pkg.
module fof_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fof_pkg::fof_status_t status_i,
  output fof_pkg::fof_cmd_t    cmd_o
);
  import fof_pkg::*;

  fof_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_WALK;
      ST_WALK:  if (status_i.walk_done) state_d = ST_DRAIN;
      ST_DRAIN: if (!status_i.pipe_busy) state_d = ST_FIN;
      ST_FIN:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_WALK:  cmd_o.issue    = !status_i.walk_done;
      ST_DRAIN: cmd_o          = '0;
      ST_FIN:   cmd_o.load_out = status_i.out_free;
      default:  cmd_o          = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/fof_datapath.sv
// Datapath: configuration registers, grain ring, per-grain pipeline and output register.
// Depends on fof_pkg and fof_ram.
module fof_datapath #(
  parameter int MAX_GRAINS = 64,
  parameter int TABLE_SIZE = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fof_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic [23:0]                     fundamental_increment_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic signed [21:0]              sample_sum_o,
  output logic [$clog2(MAX_GRAINS):0]     live_grains_o,
  output logic                            grain_overflow_o,
  input  fof_pkg::fof_cmd_t               cmd_i,
  output fof_pkg::fof_status_t            status_o
);
  import fof_pkg::*;

  localparam int PtrW = $clog2(MAX_GRAINS);
  localparam int CntW = PtrW + 1;
  localparam int IdxW = $clog2(TABLE_SIZE + 1);
  localparam int AccW = PtrW + 20;
  localparam int RamW = 32 + 24 + 1;

  // Table generation, evaluated at elaboration only.
  localparam longint TableSize = TABLE_SIZE;
  localparam longint CosDen    = TABLE_SIZE;
  localparam longint HalfDen   = 2 * TABLE_SIZE;
  localparam longint OneQ30    = 64'd1073741824;
  localparam longint HalfPiQ30 = 64'd1686629713;
  localparam longint TwoPiQ30  = 64'd6746518852;

  typedef logic signed [15:0] cos_tab_t [TABLE_SIZE+1];
  typedef logic [16:0] wt_tab_t [TABLE_SIZE+1];

  // Unsigned long division by shift and subtract, for the table builders.
  function automatic longint elab_div(longint n, longint d);
    longint unsigned q;
    longint unsigned r;
    longint unsigned un;
    longint unsigned ud;
    un = n;
    ud = d;
    q  = '0;
    r  = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], un[b]};
      if (r >= ud) begin
        r    = r - ud;
        q[b] = 1'b1;
      end
    end
    return longint'(q);
  endfunction

  function automatic longint elab_mod(longint n, longint d);
    return n - elab_div(n, d) * d;
  endfunction

  function automatic longint trig_series(longint x, bit odd);
    longint x2;
    longint term;
    longint d;
    longint sum;
    x2   = (x * x) >>> 30;
    term = odd ? x : OneQ30;
    sum  = term;
    for (int k = 1; k <= 9; k++) begin
      d    = odd ? longint'((2 * k) * (2 * k + 1)) : longint'((2 * k - 1) * (2 * k));
      term = elab_div((term * x2) >>> 30, d);
      sum  = k[0] ? sum - term : sum + term;
    end
    return (sum < 0) ? 64'd0 : sum;
  endfunction

  function automatic longint cos_turn(longint num, bit half);
    longint den;
    longint n4;
    longint q;
    longint x;
    den = half ? HalfDen : CosDen;
    n4  = 4 * num;
    q   = elab_div(n4, den) & 64'd3;
    x   = elab_div(HalfPiQ30 * elab_mod(n4, den), den);
    case (q)
      0:       return trig_series(x, 1'b0);
      1:       return -trig_series(x, 1'b1);
      2:       return -trig_series(x, 1'b0);
      default: return trig_series(x, 1'b1);
    endcase
  endfunction

  function automatic longint decay_value(longint i);
    longint y;
    longint term;
    longint sum;
    y    = elab_div(TwoPiQ30 * i, 16 * TableSize);
    term = OneQ30;
    sum  = OneQ30;
    for (int k = 1; k <= 10; k++) begin
      term = elab_div((term * y) >>> 30, longint'(k));
      sum  = k[0] ? sum - term : sum + term;
    end
    if (sum < 0) sum = 0;
    for (int k = 0; k < 4; k++) begin
      sum = (sum * sum) >>> 30;
    end
    return sum;
  endfunction

  function automatic cos_tab_t gen_cos();
    cos_tab_t t;
    longint   c;
    for (int i = 0; i <= TABLE_SIZE; i++) begin
      c    = cos_turn(longint'(i), 1'b0);
      t[i] = 16'((c + 32768) >>> 16);
    end
    return t;
  endfunction

  function automatic wt_tab_t gen_half();
    wt_tab_t t;
    longint  h;
    for (int i = 0; i <= TABLE_SIZE; i++) begin
      h    = cos_turn(longint'(i), 1'b1);
      t[i] = 17'((OneQ30 - h + 16384) >>> 15);
    end
    return t;
  endfunction

  function automatic wt_tab_t gen_decay();
    wt_tab_t t;
    for (int i = 0; i <= TABLE_SIZE; i++) begin
      t[i] = 17'((decay_value(longint'(i)) + 8192) >>> 14);
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB   = gen_cos();
  localparam wt_tab_t  HALF_TAB  = gen_half();
  localparam wt_tab_t  DECAY_TAB = gen_decay();

  localparam logic signed [AccW-1:0] SumHi = AccW'(SUM_MAX);
  localparam logic signed [AccW-1:0] SumLo = AccW'(SUM_MIN);

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    return (p == PtrW'(MAX_GRAINS - 1)) ? '0 : p + 1'b1;
  endfunction

  // Configuration.
  logic [23:0] form_inc_q;
  logic [22:0] rise_inc_q, fall_inc_q;
  logic [31:0] periods_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_inc_q <= RST_FORMANT_INC;
      rise_inc_q <= RST_RISE_INC;
      fall_inc_q <= RST_FALL_INC;
      periods_q  <= RST_PERIODS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FORMANT_INC: form_inc_q <= cfg_data_i[23:0];
        CFG_RISE_INC:    rise_inc_q <= cfg_data_i[22:0];
        CFG_FALL_INC:    fall_inc_q <= cfg_data_i[22:0];
        CFG_PERIODS:     periods_q  <= cfg_data_i;
        default:         periods_q  <= periods_q;
      endcase
    end
  end

  // Sample-level state.
  logic [24:0]     fund_q;
  logic            req_q;
  logic [PtrW-1:0] head_q, tail_q, rd_ptr_q;
  logic            ovf_q;
  logic [24:0]     fund_sum;
  logic            wrap;
  logic [PtrW-1:0] tail_nxt;

  assign fund_sum = fund_q + {1'b0, fundamental_increment_i};
  assign wrap     = fund_sum > ONE_Q24;
  assign tail_nxt = ptr_next(tail_q);

  // Pipeline stage 1: RAM read data.
  logic            s1_vld_q;
  logic [PtrW-1:0] s1_addr_q;
  logic [RamW-1:0] rdata;
  logic [31:0]     form;
  logic [23:0]     env;
  logic            falling;
  logic            rising;
  logic [23:0]     env_src;
  logic [24:0]     env_fall_sum;
  logic [23:0]     env_new;
  logic [32:0]     form_sum;
  logic [31:0]     form_new;
  logic            retire;
  logic [24+IdxW-1:0] cprod, eprod;
  logic [IdxW+1:0] eidx_raw;
  logic [IdxW-1:0] cidx, widx;

  assign form    = rdata[RamW-1 -: 32];
  assign env     = rdata[24:1];
  assign falling = rdata[0];
  assign rising  = !falling && (env <= ENV_ONE);
  assign env_src = falling ? env : 24'd0;

  assign env_fall_sum = {1'b0, env_src} + {2'b00, fall_inc_q};
  assign env_new = rising ? (env + {1'b0, rise_inc_q})
                 : (env_fall_sum[24] ? 24'hFFFFFF : env_fall_sum[23:0]);

  assign form_sum = {1'b0, form} + {9'd0, form_inc_q};
  assign form_new = form_sum[32] ? 32'hFFFFFFFF : form_sum[31:0];
  assign retire   = form_new >= periods_q;

  // Table indexes: fraction times table size, then clamp the decay index.
  assign cprod    = (24+IdxW)'(form[23:0]) * (24+IdxW)'(TABLE_SIZE);
  assign cidx     = cprod[24 +: IdxW];
  assign eprod    = (24+IdxW)'(rising ? env : env_src) * (24+IdxW)'(TABLE_SIZE);
  assign eidx_raw = eprod[22 +: IdxW+2];
  assign widx     = (eidx_raw > (IdxW+2)'(TABLE_SIZE)) ? IdxW'(TABLE_SIZE)
                                                        : eidx_raw[IdxW-1:0];

  // RAM write: grain start on accept, else writeback from stage 1.
  logic            ram_we;
  logic [PtrW-1:0] ram_waddr;
  logic [RamW-1:0] ram_wdata;
  logic            start_grain;

  assign start_grain = cmd_i.accept && req_q && (tail_nxt != head_q);
  assign ram_we      = start_grain || s1_vld_q;
  assign ram_waddr   = start_grain ? tail_q : s1_addr_q;
  assign ram_wdata   = start_grain ? '0 : {form_new, env_new, !rising};

  fof_ram #(
    .Width(RamW),
    .Depth(MAX_GRAINS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_ptr_q),
    .rdata_o(rdata)
  );

  // Stages 2 to 5.
  logic                   s2_vld_q, s3_vld_q, s4_vld_q;
  logic [IdxW-1:0]        cidx_q, widx_q;
  logic                   use_half_q;
  logic signed [15:0]     cos_q;
  logic [16:0]            wt_q;
  logic signed [33:0]     prod_q;
  logic signed [33:0]     rnd;
  logic signed [AccW-1:0] acc_q;

  assign rnd = prod_q + 34'sd16384;

  always_ff @(posedge clk_i) begin
    cidx_q     <= cidx;
    widx_q     <= widx;
    use_half_q <= rising;
    cos_q      <= COS_TAB[cidx_q];
    wt_q       <= use_half_q ? HALF_TAB[widx_q] : DECAY_TAB[widx_q];
    prod_q     <= cos_q * $signed({1'b0, wt_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fund_q    <= '0;
      req_q     <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      rd_ptr_q  <= '0;
      ovf_q     <= 1'b0;
      s1_vld_q  <= 1'b0;
      s1_addr_q <= '0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      acc_q     <= '0;
    end else begin
      s1_vld_q  <= cmd_i.issue;
      s1_addr_q <= rd_ptr_q;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      if (cmd_i.accept) begin
        fund_q   <= wrap ? (fund_sum - ONE_Q24) : fund_sum;
        req_q    <= wrap;
        ovf_q    <= req_q && (tail_nxt == head_q);
        rd_ptr_q <= head_q;
        acc_q    <= '0;
        if (start_grain) begin
          tail_q <= tail_nxt;
        end
      end else begin
        if (cmd_i.issue) begin
          rd_ptr_q <= ptr_next(rd_ptr_q);
        end
        if (s4_vld_q) begin
          acc_q <= acc_q + AccW'($signed(rnd[33:15]));
        end
      end
      if (s1_vld_q && retire) begin
        head_q <= ptr_next(s1_addr_q);
      end
    end
  end

  // Output register.
  logic [CntW-1:0] count;
  logic [21:0]     sum_sat;

  always_comb begin
    if (tail_q >= head_q) begin
      count = CntW'(tail_q) - CntW'(head_q);
    end else begin
      count = CntW'(tail_q) + CntW'(MAX_GRAINS) - CntW'(head_q);
    end
    if (acc_q > SumHi) begin
      sum_sat = SumHi[21:0];
    end else if (acc_q < SumLo) begin
      sum_sat = SumLo[21:0];
    end else begin
      sum_sat = acc_q[21:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sample_sum_o     <= sum_sat;
      live_grains_o    <= count;
      grain_overflow_o <= ovf_q;
    end
  end

  assign status_o.walk_done = (rd_ptr_q == tail_q);
  assign status_o.pipe_busy = s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q;
  assign status_o.out_free  = !out_valid_o || !out_stall_i;

endmodule

### hw/rtl/fof_grain_synth.sv
// Formant grain synthesizer top level: each audio sample in yields a mixed sample out.
// Depends on fof_pkg, fof_ctrl and fof_datapath.
//
// Each transfer on the input channel carries the fundamental phase step of one
// audio sample; each transfer on the output channel carries that sample's mixed
// value, the number of grains alive after it and a flag that tells whether a
// grain start was dropped because the ring was full. The walk of a sample visits
// every live grain (at most MAX_GRAINS - 1 of them): the grain ring sits in one
// RAM with a single read port, so the walk visits one grain per cycle, and a
// five-stage pipeline (RAM read, index multiply, table read, product,
// accumulate) must drain before the result is formed. A new sample is taken
// only once the previous one is finished, though a finished result may still
// wait on the output while the next sample is taken. The cosine, rising
// half-cosine and exponential decay tables are built at elaboration from fixed
// point series and hold TABLE_SIZE + 1 entries each. Configuration writes take
// effect at once and must only be issued while no sample is in flight.
module fof_grain_synth #(
  parameter int MAX_GRAINS = 64,
  parameter int TABLE_SIZE = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fof_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [23:0]                 fundamental_increment_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [21:0]          sample_sum_o,
  output logic [$clog2(MAX_GRAINS):0] live_grains_o,
  output logic                        grain_overflow_o
);
  import fof_pkg::*;

  fof_cmd_t    cmd;
  fof_status_t status;

  // The controller only sequences; all arithmetic and storage live in the datapath.
  fof_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  fof_datapath #(
    .MAX_GRAINS(MAX_GRAINS),
    .TABLE_SIZE(TABLE_SIZE)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .fundamental_increment_i(fundamental_increment_i),
    .out_stall_i            (out_stall_i),
    .out_valid_o            (out_valid_o),
    .sample_sum_o           (sample_sum_o),
    .live_grains_o          (live_grains_o),
    .grain_overflow_o       (grain_overflow_o),
    .cmd_i                  (cmd),
    .status_o               (status)
  );

endmodule

### hw/rtl/fof_checker.sv
// Port-level checker for the formant grain synthesizer, bound to the top level.
// Depends on fof_grain_synth.
module fof_checker #(
  parameter int MAX_GRAINS = 64
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [21:0]          sample_sum_o,
  input logic [$clog2(MAX_GRAINS):0] live_grains_o
);

  logic [1:0] pending_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_sum_o))
    else $error("Stalled output transfer changed.");

  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != 2'd0)
    else $error("Output transfer without a pending sample.");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 2'd2)
    else $error("Too many samples in flight.");

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> live_grains_o <= ($clog2(MAX_GRAINS)+1)'(MAX_GRAINS - 1))
    else $error("Live grain count exceeds ring capacity.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("Input taken again before the sample finished.");

endmodule

bind fof_grain_synth fof_checker #(.MAX_GRAINS(MAX_GRAINS)) u_fof_checker (.*);

### tb/tb_fof_grain_synth.sv
// Self-checking testbench for fof_grain_synth: random fundamental steps under
// several register settings, with results checked against an in-bench predictor.
// Depends on fof_pkg and the fof_grain_synth RTL.
`timescale 1ns / 100ps

module tb_fof_grain_synth;
  import fof_pkg::*;

  localparam int SLOTS = 64;
  localparam int TBL = 512;
  localparam int PHASES = 6;
  localparam int PER_PHASE = 165;
  localparam int IDLE_LIMIT = 5000;
  localparam longint unsigned ONE30 = 64'd1073741824;
  localparam longint unsigned HALF_PI30 = 64'd1686629713;
  localparam longint unsigned TWO_PI30 = 64'd6746518852;

  typedef struct packed {
    logic signed [21:0] sum;
    logic [6:0]         live;
    logic               ovf;
  } mix_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_FORMANT_INC;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [23:0] fundamental_increment_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [21:0] sample_sum_o;
  logic [6:0] live_grains_o;
  logic grain_overflow_o;

  fof_grain_synth dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the synthesizer registers and grain ring.
  logic [23:0] m_form_inc;
  logic [22:0] m_rise_inc, m_fall_inc;
  logic [31:0] m_periods;
  logic [31:0] m_fund;
  logic        m_request;
  int unsigned m_head, m_tail;
  logic [31:0] m_form_ph [SLOTS];
  logic [23:0] m_env_ph [SLOTS];
  logic        m_falling [SLOTS];
  longint      cos_tbl [TBL+1];
  longint      rise_tbl [TBL+1];
  longint      decay_tbl [TBL+1];

  logic [23:0]  step_q [$];
  mix_result_t  mix_q [$];
  int  errors = 0;
  bit  calm = 1'b0;
  int  idle_cycles = 0;

  function automatic longint series_q30(longint unsigned x, bit odd);
    longint unsigned x2, term, d;
    longint acc;
    x2 = (x * x) >> 30;
    term = odd ? x : ONE30;
    acc = longint'(term);
    for (int k = 1; k <= 9; k++) begin
      d = odd ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
      term = ((term * x2) >> 30) / d;
      acc += (k & 1) ? -longint'(term) : longint'(term);
    end
    return acc < 0 ? 0 : acc;
  endfunction

  // Cosine of num/den of a turn, Q30.
  function automatic longint cos_of_turn(longint unsigned num, longint unsigned den);
    longint unsigned n4, q, x;
    n4 = 4 * num;
    q = (n4 / den) & 3;
    x = HALF_PI30 * (n4 % den) / den;
    case (q)
      0: return series_q30(x, 0);
      1: return -series_q30(x, 1);
      2: return -series_q30(x, 0);
      default: return series_q30(x, 1);
    endcase
  endfunction

  // exp(-2 pi i / TBL) in Q30: series on one sixteenth, then squared four times.
  function automatic longint unsigned decay_q30(longint unsigned i);
    longint unsigned y, term, s;
    longint acc;
    y = TWO_PI30 * i / (16 * TBL);
    term = ONE30;
    acc = longint'(ONE30);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * y) >> 30) / k;
      acc += (k & 1) ? -longint'(term) : longint'(term);
    end
    s = acc < 0 ? 0 : longint'(acc);
    for (int k = 0; k < 4; k++) s = (s * s) >> 30;
    return s;
  endfunction

  task automatic build_tables();
    longint c, h;
    for (int i = 0; i <= TBL; i++) begin
      c = cos_of_turn(i, TBL);
      h = cos_of_turn(i, 2 * TBL);
      cos_tbl[i] = (c + 32768) >>> 16;
      rise_tbl[i] = (longint'(ONE30) - h + 16384) >>> 15;
      decay_tbl[i] = longint'((decay_q30(i) + 8192) >> 14);
    end
  endtask

  function automatic int unsigned ring_after(int unsigned i);
    return (i + 1 >= SLOTS) ? 0 : i + 1;
  endfunction

  // Advance the predictor by one audio sample and return the mixed result.
  task automatic mix_sample(input logic [23:0] step, output mix_result_t res);
    longint acc, val;
    longint unsigned env, idx, fp;
    int unsigned cur, nt;
    logic ovf;
    acc = 0;
    ovf = 1'b0;
    m_fund = m_fund + step;
    if (m_request) begin
      nt = ring_after(m_tail);
      if (nt == m_head) begin
        ovf = 1'b1;
      end else begin
        m_form_ph[m_tail] = '0;
        m_env_ph[m_tail] = '0;
        m_falling[m_tail] = 1'b0;
        m_tail = nt;
      end
      m_request = 1'b0;
    end
    cur = m_head;
    while (cur != m_tail) begin
      val = cos_tbl[(longint'(m_form_ph[cur][23:0]) * TBL) >> 24];
      env = m_env_ph[cur];
      if (!m_falling[cur] && env <= ENV_ONE) begin
        val = (val * rise_tbl[(env * TBL) >> 22] + 16384) >>> 15;
        m_env_ph[cur] = 24'(env + m_rise_inc);
      end else if (!m_falling[cur]) begin
        m_falling[cur] = 1'b1;
        m_env_ph[cur] = '0;
      end
      if (m_falling[cur]) begin
        env = m_env_ph[cur];
        idx = (env * TBL) >> 22;
        if (idx > TBL) idx = TBL;
        val = (val * decay_tbl[idx] + 16384) >>> 15;
        env += m_fall_inc;
        m_env_ph[cur] = (env > 64'hFFFFFF) ? 24'hFFFFFF : env[23:0];
      end
      fp = longint'(m_form_ph[cur]) + m_form_inc;
      if (fp > 64'hFFFFFFFF) fp = 64'hFFFFFFFF;
      m_form_ph[cur] = fp[31:0];
      if (fp >= m_periods) m_head = ring_after(cur);
      acc += val;
      cur = ring_after(cur);
    end
    if (m_fund > ONE_Q24) begin
      m_fund -= ONE_Q24;
      m_request = 1'b1;
    end
    if (acc > SUM_MAX) acc = SUM_MAX;
    if (acc < SUM_MIN) acc = SUM_MIN;
    res.sum = acc[21:0];
    res.live = 7'((m_tail + SLOTS - m_head) % SLOTS);
    res.ovf = ovf;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: offers a queued step when free, with random gaps outside the calm phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (step_q.size() > 0 && (calm || $urandom_range(99) >= 12)) begin
        in_valid_i <= 1'b1;
        fundamental_increment_i <= step_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall pattern: random back-pressure except in the calm phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 12);
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk_i) begin
    mix_result_t res, want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        mix_sample(fundamental_increment_i, res);
        mix_q.push_back(res);
      end
      if (out_valid_o && !out_stall_i) begin
        if (mix_q.size() == 0) begin
          report("unexpected result", sample_sum_o, 0);
        end else begin
          want = mix_q.pop_front();
          if (sample_sum_o !== want.sum) report("sample_sum", sample_sum_o, want.sum);
          if (live_grains_o !== want.live) report("live_grains", live_grains_o, want.live);
          if (grain_overflow_o !== want.ovf) report("grain_overflow", grain_overflow_o, want.ovf);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("fof_grain_synth verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_FORMANT_INC: m_form_inc = val[23:0];
      CFG_RISE_INC:    m_rise_inc = val[22:0];
      CFG_FALL_INC:    m_fall_inc = val[22:0];
      default:         m_periods = val;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] fi, input logic [31:0] ri,
                          input logic [31:0] fa, input logic [31:0] gp);
    write_reg(CFG_FORMANT_INC, fi);
    write_reg(CFG_RISE_INC, ri);
    write_reg(CFG_FALL_INC, fa);
    write_reg(CFG_PERIODS, gp);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold off until the block has drained every expected result.
  task automatic drain();
    wait (step_q.size() == 0 && !in_valid_i && mix_q.size() == 0);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [23:0] random_step();
    case ($urandom_range(3))
      0, 1: return 24'($urandom_range(24'hFFFFFF, 24'h400000));
      2: return 24'($urandom_range(24'hFFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    m_form_inc = RST_FORMANT_INC;
    m_rise_inc = RST_RISE_INC;
    m_fall_inc = RST_FALL_INC;
    m_periods = RST_PERIODS;
    m_fund = '0;
    m_request = 1'b0;
    m_head = 0;
    m_tail = 0;
    build_tables();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed start with reset registers: zero and full steps, an exact 1.0
    // accumulation that must not wrap, then steps that start many grains.
    step_q = '{24'h0, 24'hFFFFFF, 24'h1, 24'h800000, 24'h800000, 24'h7FFFFF,
               24'hAAAAAA, 24'h555555, 24'h000001, 24'hFFFFFE};
    for (int i = 0; i < 14; i++) step_q.push_back(24'hF00000 + i);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_regs(RST_FORMANT_INC, RST_RISE_INC, RST_FALL_INC, RST_PERIODS);
        // Largest formant step with zero life: every grain retires in its first sample.
        1: set_regs(32'hFFFFFF, 32'd4194304, 32'd4194304, 32'h0);
        // Frozen formant, zero attack step, endless life: the ring fills.
        2: set_regs(32'h0, 32'h0, 32'h0, 32'hFFFFFFFF);
        3: set_regs($urandom, $urandom_range(4194304), $urandom_range(4194304),
                    $urandom_range(32'h4000000));
        4: set_regs($urandom_range(24'h80000), $urandom_range(300000),
                    $urandom_range(40000), $urandom);
        default: set_regs(RST_FORMANT_INC, RST_RISE_INC, RST_FALL_INC, RST_PERIODS);
      endcase
      calm = (ph == 4);
      for (int i = 0; i < PER_PHASE; i++) step_q.push_back(random_step());
      drain();
    end

    calm = 1'b0;
    if (errors == 0) begin
      $display("fof_grain_synth verification clean");
    end else begin
      $display("fof_grain_synth verification failed");
    end
    $finish;
  end

endmodule
